>>> rtl/brm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brm_pkg: shared types and constants of the binary descriptor ratio matcher
// Field widths, action and register codes, reset values and state encodings.
// ----------------------------------------------------------------------------
package brm_pkg;

	localparam int WORD_W     = 64;
	localparam int DESC_W     = 4 * WORD_W;
	localparam int ACT_W      = 2;
	localparam int IDX_W      = 10;
	localparam int DIST_W     = 9;
	localparam int PROD_W     = 2 * DIST_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	// Indexes that the cand_index field can name at all.
	localparam int INDEX_SPAN = 1 << IDX_W;

	localparam logic [DIST_W-1:0] NO_DIST = 9'd256;

	localparam logic [DIST_W-1:0] LIMIT_RESET = 9'd100;
	localparam logic [DIST_W-1:0] RATIO_RESET = 9'd179;
	localparam logic              EXCL_RESET  = 1'b1;

	// Taken marks are tagged with a frame epoch; tag zero never matches.
	localparam int                EPOCH_W     = 8;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'd255;

	// Result words buffered ahead of the output port.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 3);

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD  = 2'd0,
		ACT_CAND  = 2'd1,
		ACT_FRAME = 2'd2
	} brm_action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LIMIT = 2'd0,
		CFG_RATIO = 2'd1,
		CFG_EXCL  = 2'd2
	} brm_cfg_idx_t;

	typedef enum logic [1:0] {
		MAP_CLEAR = 2'd0,
		MAP_DRAIN = 2'd1,
		MAP_READY = 2'd2
	} brm_map_state_t;

	typedef struct packed {
		logic              match_found;
		logic [IDX_W-1:0]  best_index;
		logic [DIST_W-1:0] best_distance;
		logic [DIST_W-1:0] second_distance;
	} brm_result_t;

endpackage
`default_nettype wire

>>> rtl/brm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brm_if: channel interfaces of the binary descriptor ratio matcher
// Input word channel, result word channel and configuration write channel.
// ----------------------------------------------------------------------------
interface brm_item_if;
	import brm_pkg::*;

	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [WORD_W-1:0] desc_word0;
	logic [WORD_W-1:0] desc_word1;
	logic [WORD_W-1:0] desc_word2;
	logic [WORD_W-1:0] desc_word3;
	logic [IDX_W-1:0]  cand_index;
	logic              cand_skip;
	logic              cand_last;

	modport source (
		output valid, action, desc_word0, desc_word1, desc_word2, desc_word3,
		       cand_index, cand_skip, cand_last,
		input  ready
	);
	modport sink (
		input  valid, action, desc_word0, desc_word1, desc_word2, desc_word3,
		       cand_index, cand_skip, cand_last,
		output ready
	);
endinterface

interface brm_result_if;
	import brm_pkg::*;

	logic              valid;
	logic              ready;
	logic              match_found;
	logic [IDX_W-1:0]  best_index;
	logic [DIST_W-1:0] best_distance;
	logic [DIST_W-1:0] second_distance;

	modport source (
		output valid, match_found, best_index, best_distance, second_distance,
		input  ready
	);
	modport sink (
		input  valid, match_found, best_index, best_distance, second_distance,
		output ready
	);
endinterface

interface brm_cfg_if;
	import brm_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface
`default_nettype wire

>>> rtl/brm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brm_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module brm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

>>> rtl/binary_descriptor_ratio_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_descriptor_ratio_matcher: Hamming matcher with a ratio test
// Streams candidate descriptors against a loaded query and reports the best
// candidate of each run, with a reverse-match map for exclusive matching.
// ----------------------------------------------------------------------------
// Usage: send a load word with the 256-bit query, then a run of candidate
// words; the candidate word flagged last yields one result word on the result
// channel. A new-frame word clears the taken map. Configuration words on the
// cfg channel are always accepted and should be sent while the block is idle.
//
// Throughput is one input word per cycle unless a map sweep or a full buffer
// stalls the input. Stage 1 computes the 256-bit popcount, stage 2 checks the
// taken map, updates the run and writes the result word into the buffer.
// Up to four result words are buffered, so input words keep flowing while the
// receiver stalls; once the buffer and the pipeline hold four words in total,
// the input side stalls until the receiver takes a word.
//
// After reset the taken map, MAX_FEATURES entries (1024 at most), is swept
// before the first input word is accepted. Taken marks carry a frame epoch, so
// a new-frame word does not stall the input, except every 255th one, which
// waits for the pipeline to drain and then sweeps the map again.
// ----------------------------------------------------------------------------
module binary_descriptor_ratio_matcher #(
	parameter int MAX_FEATURES = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	brm_item_if.sink      item,
	brm_result_if.source  result,
	brm_cfg_if.sink       cfg
);
	import brm_pkg::*;

	localparam int MAP_DEPTH = (MAX_FEATURES > INDEX_SPAN) ? INDEX_SPAN : MAX_FEATURES;
	localparam int AW        = $clog2(MAP_DEPTH);

	function automatic logic [6:0] ones64(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] v1;
		logic [WORD_W-1:0] v2;
		logic [WORD_W-1:0] v3;
		logic [6:0]        sum;
		v1  = v - ((v >> 1) & 64'h5555_5555_5555_5555);
		v2  = (v1 & 64'h3333_3333_3333_3333) + ((v1 >> 2) & 64'h3333_3333_3333_3333);
		v3  = (v2 + (v2 >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
		sum = '0;
		for (int i = 0; i < 8; i++) begin
			sum = sum + {3'b000, v3[8*i +: 4]};
		end
		return sum;
	endfunction

	// Configuration registers
	logic [DIST_W-1:0] limit_q;
	logic [DIST_W-1:0] ratio_q;
	logic              excl_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			ratio_q <= RATIO_RESET;
			excl_q  <= EXCL_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_LIMIT: limit_q <= cfg.data;
				CFG_RATIO: ratio_q <= cfg.data;
				CFG_EXCL:  excl_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Map sweep control and frame epoch
	brm_map_state_t    map_state_q;
	brm_map_state_t    map_state_d;
	logic [AW-1:0]     clr_cnt_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic              clearing;
	logic              frame_wrap;

	// Pipeline valid bits and result buffer occupancy
	logic               v_s1;
	logic               v_s2;
	logic [FIFO_CW-1:0] fifo_cnt_q;
	logic [FIFO_CW-1:0] in_flight;
	logic               item_fire;

	assign in_flight  = fifo_cnt_q + {{(FIFO_CW-1){1'b0}}, v_s1}
	                    + {{(FIFO_CW-1){1'b0}}, v_s2};
	assign item.ready = (map_state_q == MAP_READY) && (in_flight < FIFO_CW'(FIFO_DEPTH));
	assign item_fire  = item.valid && item.ready;
	assign frame_wrap = item_fire && (item.action == ACT_FRAME) && (epoch_q == EPOCH_LAST);

	always_comb begin
		map_state_d = map_state_q;
		clearing    = 1'b0;
		case (map_state_q)
			MAP_CLEAR: begin
				clearing = 1'b1;
				if (clr_cnt_q == AW'(MAP_DEPTH - 1)) begin
					map_state_d = MAP_READY;
				end
			end
			MAP_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					map_state_d = MAP_CLEAR;
				end
			end
			MAP_READY: begin
				if (frame_wrap) begin
					map_state_d = MAP_DRAIN;
				end
			end
			default: map_state_d = MAP_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_state_q <= MAP_CLEAR;
			clr_cnt_q   <= '0;
			epoch_q     <= EPOCH_FIRST;
		end else begin
			map_state_q <= map_state_d;
			if (clearing) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end else begin
				clr_cnt_q <= '0;
			end
			if (item_fire && (item.action == ACT_FRAME)) begin
				if (epoch_q == EPOCH_LAST) begin
					epoch_q <= EPOCH_FIRST;
				end else begin
					epoch_q <= epoch_q + 1'b1;
				end
			end
		end
	end

	// Query register, written when the load word is accepted
	logic [DESC_W-1:0] query_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_q <= '0;
		end else if (item_fire && (item.action == ACT_LOAD)) begin
			query_q <= {item.desc_word3, item.desc_word2, item.desc_word1, item.desc_word0};
		end
	end

	// Stage 1: input register, popcount of the descriptor difference
	logic [ACT_W-1:0]   action_s1;
	logic [DESC_W-1:0]  desc_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               skip_s1;
	logic               last_s1;
	logic [EPOCH_W-1:0] epoch_s1;
	logic [DESC_W-1:0]  diff_s1;
	logic [DIST_W-1:0]  dist_s1;
	logic               in_map_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= item_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			action_s1 <= item.action;
			desc_s1   <= {item.desc_word3, item.desc_word2, item.desc_word1, item.desc_word0};
			idx_s1    <= item.cand_index;
			skip_s1   <= item.cand_skip;
			last_s1   <= item.cand_last;
			epoch_s1  <= epoch_q;
		end
	end

	assign diff_s1   = desc_s1 ^ query_q;
	assign dist_s1   = {2'b00, ones64(diff_s1[0 +: WORD_W])}
	                   + {2'b00, ones64(diff_s1[WORD_W +: WORD_W])}
	                   + {2'b00, ones64(diff_s1[2*WORD_W +: WORD_W])}
	                   + {2'b00, ones64(diff_s1[3*WORD_W +: WORD_W])};
	assign in_map_s1 = (32'(idx_s1) < 32'(MAP_DEPTH));

	// Taken map: epoch tags, read in stage 1, checked in stage 2
	logic               map_we;
	logic [AW-1:0]      map_waddr;
	logic [EPOCH_W-1:0] map_wdata;
	logic [EPOCH_W-1:0] tag_s2;
	logic               mark_we;
	logic [AW-1:0]      mark_addr;

	assign map_we    = clearing || mark_we;
	assign map_waddr = clearing ? clr_cnt_q : mark_addr;

	brm_ram #(
		.WIDTH (EPOCH_W),
		.DEPTH (MAP_DEPTH)
	) u_taken_map (
		.clk     (clk),
		.wr_en   (map_we),
		.wr_addr (map_waddr),
		.wr_data (map_wdata),
		.rd_addr (idx_s1[AW-1:0]),
		.rd_data (tag_s2)
	);

	// Stage 2: run update and ratio test
	logic [ACT_W-1:0]   action_s2;
	logic [DIST_W-1:0]  dist_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic               elig_s2;
	logic               last_s2;
	logic [EPOCH_W-1:0] epoch_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		action_s2 <= action_s1;
		dist_s2   <= dist_s1;
		idx_s2    <= idx_s1;
		elig_s2   <= !skip_s1 && in_map_s1;
		last_s2   <= last_s1;
		epoch_s2  <= epoch_s1;
	end

	// The mark written at the edge that registered tag_s2 is not in the read
	// data yet, so the last write is kept and compared here.
	logic               wr_v_q;
	logic [AW-1:0]      wr_addr_q;
	logic [EPOCH_W-1:0] wr_epoch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_v_q <= 1'b0;
		end else begin
			wr_v_q <= mark_we;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q  <= mark_addr;
		wr_epoch_q <= epoch_s2;
	end

	logic [DIST_W-1:0] run_best_q;
	logic [DIST_W-1:0] run_second_q;
	logic [IDX_W-1:0]  run_idx_q;
	logic              run_seen_q;

	logic              is_cand;
	logic              taken;
	logic              counted;
	logic              new_best_hit;
	logic              new_second_hit;
	logic [DIST_W-1:0] best_nx;
	logic [DIST_W-1:0] second_nx;
	logic [IDX_W-1:0]  idx_nx;
	logic              seen_nx;
	logic [PROD_W-1:0] prod_second;
	logic [PROD_W-1:0] prod_best;
	logic [PROD_W-1:0] prod_dist;
	logic [PROD_W-1:0] prod_sel;
	logic [PROD_W-1:0] best_scaled;
	logic              accept;
	logic              push;

	assign is_cand = v_s2 && (action_s2 == ACT_CAND);
	assign taken   = (tag_s2 == epoch_s2)
	                 || (wr_v_q && (wr_addr_q == idx_s2[AW-1:0]) && (wr_epoch_q == epoch_s2));
	assign counted = is_cand && elig_s2 && !taken;

	assign new_best_hit   = counted && (dist_s2 < run_best_q);
	assign new_second_hit = counted && !new_best_hit && (dist_s2 < run_second_q);

	// All three candidate products are formed in parallel; the update picks one.
	assign prod_second = PROD_W'(ratio_q) * PROD_W'(run_second_q);
	assign prod_best   = PROD_W'(ratio_q) * PROD_W'(run_best_q);
	assign prod_dist   = PROD_W'(ratio_q) * PROD_W'(dist_s2);

	always_comb begin
		best_nx   = run_best_q;
		second_nx = run_second_q;
		idx_nx    = run_idx_q;
		prod_sel  = prod_second;
		if (new_best_hit) begin
			best_nx   = dist_s2;
			second_nx = run_best_q;
			idx_nx    = idx_s2;
			prod_sel  = prod_best;
		end else if (new_second_hit) begin
			second_nx = dist_s2;
			prod_sel  = prod_dist;
		end
	end

	assign seen_nx     = run_seen_q || counted;
	assign best_scaled = {1'b0, best_nx, 8'h00};
	assign accept      = seen_nx && (best_nx < limit_q) && (best_scaled < prod_sel);
	assign push        = is_cand && last_s2;
	assign mark_we     = push && accept && excl_q;
	assign mark_addr   = idx_nx[AW-1:0];
	assign map_wdata   = clearing ? '0 : epoch_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_best_q   <= NO_DIST;
			run_second_q <= NO_DIST;
			run_idx_q    <= '0;
			run_seen_q   <= 1'b0;
		end else if (v_s2) begin
			case (action_s2)
				ACT_LOAD, ACT_FRAME: begin
					run_best_q   <= NO_DIST;
					run_second_q <= NO_DIST;
					run_idx_q    <= '0;
					run_seen_q   <= 1'b0;
				end
				ACT_CAND: begin
					if (last_s2) begin
						run_best_q   <= NO_DIST;
						run_second_q <= NO_DIST;
						run_idx_q    <= '0;
						run_seen_q   <= 1'b0;
					end else begin
						run_best_q   <= best_nx;
						run_second_q <= second_nx;
						run_idx_q    <= idx_nx;
						run_seen_q   <= seen_nx;
					end
				end
				default: ;
			endcase
		end
	end

	// Result buffer
	brm_result_t        fifo_q [FIFO_DEPTH];
	logic [FIFO_PW-1:0] wptr_q;
	logic [FIFO_PW-1:0] rptr_q;
	logic               pop;
	brm_result_t        head;

	assign pop  = result.valid && result.ready;
	assign head = fifo_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q     <= '0;
			rptr_q     <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fifo_cnt_q <= fifo_cnt_q + 1'b1;
				2'b01:   fifo_cnt_q <= fifo_cnt_q - 1'b1;
				default: fifo_cnt_q <= fifo_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= '{
				match_found:     accept,
				best_index:      idx_nx,
				best_distance:   best_nx,
				second_distance: second_nx
			};
		end
	end

	assign result.valid           = (fifo_cnt_q != '0);
	assign result.match_found     = head.match_found;
	assign result.best_index      = head.best_index;
	assign result.best_distance   = head.best_distance;
	assign result.second_distance = head.second_distance;

endmodule
`default_nettype wire

>>> tb/tb_binary_descriptor_ratio_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_binary_descriptor_ratio_matcher: self-checking bench for the matcher
// Loads queries and streams candidate runs through the item channel while both
// sides stall at random, predicts each run's best and second-best Hamming
// distances, the ratio test and the taken map, and checks every result word.
// ----------------------------------------------------------------------------
module tb_binary_descriptor_ratio_matcher;
	import brm_pkg::*;

	localparam int MAP_SIZE = 1024;
	localparam int IDLE_GAP = 8;
	localparam int PHASES   = 6;
	localparam int PHASE_WORDS = 258;

	// The action field can carry a code that the block must ignore.
	localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

	class match_scoreboard;
		logic [DIST_W-1:0] limit_reg;
		logic [DIST_W-1:0] ratio_reg;
		logic              excl_reg;
		logic [DESC_W-1:0] query;
		logic [DIST_W-1:0] run_best;
		logic [DIST_W-1:0] run_second;
		logic [IDX_W-1:0]  run_index;
		bit                run_seen;
		bit [MAP_SIZE-1:0] taken;
		brm_result_t       expected_results[$];
		int                errors;
		int                checked;
		int                match_count;

		function new();
			limit_reg   = LIMIT_RESET;
			ratio_reg   = RATIO_RESET;
			excl_reg    = EXCL_RESET;
			query       = '0;
			taken       = '0;
			errors      = 0;
			checked     = 0;
			match_count = 0;
			fresh_run();
		endfunction

		function void fresh_run();
			run_best   = NO_DIST;
			run_second = NO_DIST;
			run_index  = '0;
			run_seen   = 1'b0;
		endfunction

		function void write_reg(brm_cfg_idx_t r, logic [CFG_DATA_W-1:0] v);
			case (r)
				CFG_LIMIT: limit_reg = v;
				CFG_RATIO: ratio_reg = v;
				CFG_EXCL:  excl_reg  = v[0];
				default: ;
			endcase
		endfunction

		function void note_word(logic [ACT_W-1:0] act, logic [DESC_W-1:0] desc,
				logic [IDX_W-1:0] idx, logic skip, logic last);
			logic [DIST_W-1:0] cand_dist;
			bit                accept;
			brm_result_t       res;
			case (act)
				ACT_LOAD: begin
					query = desc;
					fresh_run();
				end
				ACT_FRAME: begin
					taken = '0;
					fresh_run();
				end
				ACT_CAND: begin
					if (!skip && idx < MAP_SIZE && !taken[idx]) begin
						cand_dist = DIST_W'($countones(query ^ desc));
						run_seen = 1'b1;
						if (cand_dist < run_best) begin
							run_second = run_best;
							run_best   = cand_dist;
							run_index  = idx;
						end else if (cand_dist < run_second) begin
							run_second = cand_dist;
						end
					end
					if (last) begin
						accept = run_seen && run_best < limit_reg &&
							(int'(run_best) * 256 < int'(ratio_reg) * int'(run_second));
						if (accept && excl_reg && run_index < MAP_SIZE)
							taken[run_index] = 1'b1;
						res.match_found     = accept;
						res.best_index      = run_index;
						res.best_distance   = run_best;
						res.second_distance = run_second;
						expected_results.push_back(res);
						fresh_run();
					end
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(brm_result_t got);
			brm_result_t want;
			if (expected_results.size() == 0) begin
				report("result word arrived with nothing pending");
			end else begin
				want = expected_results.pop_front();
				checked++;
				if (want.match_found)
					match_count++;
				if (got.match_found !== want.match_found)
					report($sformatf("match_found got %0b expected %0b",
						got.match_found, want.match_found));
				if (got.best_index !== want.best_index)
					report($sformatf("best_index got %0d expected %0d",
						got.best_index, want.best_index));
				if (got.best_distance !== want.best_distance)
					report($sformatf("best_distance got %0d expected %0d",
						got.best_distance, want.best_distance));
				if (got.second_distance !== want.second_distance)
					report($sformatf("second_distance got %0d expected %0d",
						got.second_distance, want.second_distance));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	brm_item_if   item_ch();
	brm_result_if res_ch();
	brm_cfg_if    cfg_ch();

	binary_descriptor_ratio_matcher #(
		.MAX_FEATURES(MAP_SIZE)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	match_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int words_sent;

	logic [DIST_W-1:0] limit_set [PHASES] = '{9'd100, 9'd257, 9'd0, 9'd60, 9'd256, 9'd30};
	logic [DIST_W-1:0] ratio_set [PHASES] = '{9'd179, 9'd256, 9'd0, 9'd200, 9'd128, 9'd230};
	logic              excl_set  [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("FAIL binary_descriptor_ratio_matcher");
		$finish;
	end

	function automatic logic [DESC_W-1:0] rand_desc();
		logic [DESC_W-1:0] d;
		for (int i = 0; i < DESC_W / 32; i++)
			d[i*32 +: 32] = $urandom;
		return d;
	endfunction

	function automatic logic [DESC_W-1:0] near_desc(logic [DESC_W-1:0] base, int flips);
		logic [DESC_W-1:0] m;
		m = '0;
		for (int i = 0; i < flips; i++)
			m[$urandom_range(DESC_W-1)] = 1'b1;
		return base ^ m;
	endfunction

	task automatic send_word(input logic [ACT_W-1:0] act, input logic [DESC_W-1:0] d,
			input logic [IDX_W-1:0] idx, input logic skip, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.action     <= act;
		item_ch.desc_word0 <= d[63:0];
		item_ch.desc_word1 <= d[127:64];
		item_ch.desc_word2 <= d[191:128];
		item_ch.desc_word3 <= d[255:192];
		item_ch.cand_index <= idx;
		item_ch.cand_skip  <= skip;
		item_ch.cand_last  <= last;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_word(act, d, idx, skip, last);
		if (act != ACT_NONE)
			words_sent++;
	endtask

	task automatic set_register(input brm_cfg_idx_t r, input logic [CFG_DATA_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= r;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(r, v);
	endtask

	// A candidate word without the last flag yields no result, so the bench waits
	// a further idle gap after the last result before the block counts as idle.
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic directed_words();
		logic [DESC_W-1:0] q;
		q = rand_desc();
		send_word(ACT_LOAD, '0, 10'd0, 1'b0, 1'b0);
		// A distance of 256 counts the run but never beats the empty best.
		send_word(ACT_CAND, '1, 10'd5, 1'b0, 1'b0);
		send_word(ACT_CAND, {{(DESC_W-1){1'b0}}, 1'b1}, 10'd7, 1'b0, 1'b0);
		// A tie with the best goes to second and keeps the first index.
		send_word(ACT_CAND, {1'b1, {(DESC_W-1){1'b0}}}, 10'd9, 1'b0, 1'b1);
		send_word(ACT_LOAD, '1, 10'd1023, 1'b1, 1'b1);
		send_word(ACT_CAND, '1, 10'd1023, 1'b0, 1'b0);
		send_word(ACT_CAND, '1, 10'd0, 1'b1, 1'b0);
		send_word(ACT_CAND, '0, 10'd2, 1'b0, 1'b1);
		// Index 1023 is now taken, so this run counts nothing.
		send_word(ACT_CAND, '1, 10'd1023, 1'b0, 1'b1);
		send_word(ACT_NONE, rand_desc(), 10'd1023, 1'b1, 1'b1);
		send_word(ACT_FRAME, rand_desc(), 10'd511, 1'b1, 1'b1);
		send_word(ACT_CAND, '1, 10'd1023, 1'b0, 1'b1);
		send_word(ACT_CAND, rand_desc(), 10'd3, 1'b1, 1'b1);
		send_word(ACT_LOAD, q, 10'd0, 1'b0, 1'b0);
		send_word(ACT_CAND, near_desc(q, 3), 10'd100, 1'b0, 1'b0);
		send_word(ACT_CAND, near_desc(q, 20), 10'd101, 1'b0, 1'b1);
		send_word(ACT_CAND, q, 10'd100, 1'b0, 1'b0);
		send_word(ACT_CAND, near_desc(q, 99), 10'd200, 1'b0, 1'b1);
	endtask

	task automatic random_traffic(input int target);
		logic [DESC_W-1:0] q;
		logic [DESC_W-1:0] d;
		logic [IDX_W-1:0]  idx;
		logic              skip;
		logic              last;
		int                sent;
		int                n;
		int                r;
		int                kind;
		sent = 0;
		q = rand_desc();
		while (sent < target) begin
			r = $urandom_range(99);
			if (r < 5) begin
				send_word(ACT_FRAME, rand_desc(), IDX_W'($urandom), 1'($urandom),
					1'($urandom));
				sent++;
			end else if (r < 8) begin
				send_word(ACT_NONE, rand_desc(), IDX_W'($urandom), 1'($urandom),
					1'($urandom));
			end else begin
				// Most runs start from a fresh query; the rest keep the old one.
				if ($urandom_range(9) != 0) begin
					case ($urandom_range(19))
						0: q = '0;
						1: q = '1;
						default: q = rand_desc();
					endcase
					send_word(ACT_LOAD, q, IDX_W'($urandom), 1'($urandom), 1'($urandom));
					sent++;
				end
				n = $urandom_range(1, 8);
				for (int j = 0; j < n; j++) begin
					kind = $urandom_range(99);
					if (kind < 55)
						d = near_desc(q, $urandom_range(0, $urandom_range(1) ? 12 : 60));
					else if (kind < 75)
						d = rand_desc();
					else if (kind < 85)
						d = q;
					else if (kind < 90)
						d = ~q;
					else
						d = near_desc(q, $urandom_range(60, 120));
					idx  = $urandom_range(1) ? IDX_W'($urandom_range(0, 15))
					                         : IDX_W'($urandom_range(0, MAP_SIZE-1));
					skip = ($urandom_range(9) == 0);
					// Now and then a run is left open; a following load or new-frame word restarts it.
					last = (j == n - 1) && ($urandom_range(19) != 0);
					send_word(ACT_CAND, d, idx, skip, last);
					sent++;
				end
			end
		end
	endtask

	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready)
				sb.check_result('{res_ch.match_found, res_ch.best_index,
					res_ch.best_distance, res_ch.second_distance});
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		sb = new();
		words_sent = 0;
		send_idle_pct = 24;
		recv_idle_pct = 65;
		arst_n = 1'b0;
		item_ch.valid      = 1'b0;
		item_ch.action     = ACT_LOAD;
		item_ch.desc_word0 = '0;
		item_ch.desc_word1 = '0;
		item_ch.desc_word2 = '0;
		item_ch.desc_word3 = '0;
		item_ch.cand_index = '0;
		item_ch.cand_skip  = 1'b0;
		item_ch.cand_last  = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_LIMIT;
		cfg_ch.data  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		directed_words();
		for (int p = 0; p < PHASES; p++) begin
			// Two register settings per stall pattern.
			case (p / 2)
				0: begin send_idle_pct = 24; recv_idle_pct = 65; end
				1: begin send_idle_pct = 65; recv_idle_pct = 24; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			wait_idle();
			set_register(CFG_LIMIT, limit_set[p]);
			set_register(CFG_RATIO, ratio_set[p]);
			set_register(CFG_EXCL, {{(CFG_DATA_W-1){1'b0}}, excl_set[p]});
			cfg_ch.valid <= 1'b0;
			random_traffic(PHASE_WORDS);
		end
		wait_idle();

		$display("Sent %0d input words over %0d register settings and three stall patterns.",
			words_sent, PHASES);
		$display("Checked %0d result words, %0d of them matches; %0d mismatches.",
			sb.checked, sb.match_count, sb.errors);
		if (sb.errors == 0)
			$display("PASS binary_descriptor_ratio_matcher");
		else
			$display("FAIL binary_descriptor_ratio_matcher");
		$finish;
	end

endmodule
`default_nettype wire

>>> files.f
rtl/brm_pkg.sv
rtl/brm_if.sv
rtl/brm_ram.sv
rtl/binary_descriptor_ratio_matcher.sv
tb/tb_binary_descriptor_ratio_matcher.sv
